FILE: rtl/awd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awd_pkg
// Shared types, constants and the CORDIC angle table of the arctangent
// waveshaper.
// ----------------------------------------------------------------------------
package awd_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_POS_GAIN    = 2'd0;
    localparam logic [1:0] CFG_NEG_GAIN    = 2'd1;
    localparam logic [1:0] CFG_INVERT      = 2'd2;
    localparam logic [1:0] CFG_STAGE_COUNT = 2'd3;

    localparam int GAIN_BITS    = 16;
    localparam int CFG_BITS     = 16;
    localparam int COUNT_BITS   = 4;
    localparam int ANGLE_BITS   = 30;
    localparam int CORDIC_STEPS = 30;
    // rotation datapath: argument stays below 2^39, x grows by the cordic gain
    localparam int CW = 42;
    // angle accumulator, total table sum is below 2^31
    localparam int ZW = 33;
    // unsigned angle and divider widths
    localparam int AW = 31;

    // per-word control that travels with the data
    typedef struct packed {
        logic valid;
        logic neg;
        logic act;
        logic byp;
    } t_ctl;

    // one cordic vectoring lane
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_rot;

    // atan(2^-k) in units of 2^-30 rad
    function automatic logic signed [ZW-1:0] atan_entry(input int k);
        logic signed [ZW-1:0] v;
        case (k)
            0:  v = 33'sh03243F6A8;
            1:  v = 33'sh01DAC6705;
            2:  v = 33'sh00FADBAFC;
            3:  v = 33'sh007F56EA6;
            4:  v = 33'sh003FEAB76;
            5:  v = 33'sh001FFD55B;
            6:  v = 33'sh000FFFAAA;
            7:  v = 33'sh0007FFF55;
            8:  v = 33'sh0003FFFEA;
            9:  v = 33'sh0001FFFFD;
            10: v = 33'sh0000FFFFF;
            11: v = 33'sh00007FFFF;
            12: v = 33'sh00003FFFF;
            13: v = 33'sh00001FFFF;
            14: v = 33'sh00000FFFF;
            15: v = 33'sh000007FFF;
            16: v = 33'sh000003FFF;
            17: v = 33'sh000001FFF;
            18: v = 33'sh000000FFF;
            19: v = 33'sh0000007FF;
            20: v = 33'sh0000003FF;
            21: v = 33'sh0000001FF;
            22: v = 33'sh0000000FF;
            23: v = 33'sh00000007F;
            24: v = 33'sh00000003F;
            25: v = 33'sh00000001F;
            26: v = 33'sh00000000F;
            27: v = 33'sh000000008;
            28: v = 33'sh000000004;
            29: v = 33'sh000000002;
            default: v = '0;
        endcase
        return v;
    endfunction

    // one vectoring iteration, shifts floor toward minus infinity
    function automatic t_rot cordic_step(input t_rot a, input int k);
        t_rot r;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        xs = a.x >>> k;
        ys = a.y >>> k;
        if (!a.y[CW-1]) begin
            r.x = a.x + ys;
            r.y = a.y - xs;
            r.z = a.z + atan_entry(k);
        end else begin
            r.x = a.x - ys;
            r.y = a.y + xs;
            r.z = a.z - atan_entry(k);
        end
        return r;
    endfunction

endpackage

FILE: rtl/awd_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awd_cordic_cell
// One cordic vectoring iteration for the numerator and denominator lanes.
// ----------------------------------------------------------------------------
module awd_cordic_cell #(
    parameter int STEP     = 0,
    parameter int MAG_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  awd_pkg::t_rot         i_num,
    input  awd_pkg::t_rot         i_den,
    input  logic [MAG_BITS-1:0]   i_mag,
    input  awd_pkg::t_ctl         i_ctl,
    output awd_pkg::t_rot         o_num,
    output awd_pkg::t_rot         o_den,
    output logic [MAG_BITS-1:0]   o_mag,
    output awd_pkg::t_ctl         o_ctl
);
    import awd_pkg::*;

    t_rot r_num;
    t_rot r_den;
    logic [MAG_BITS-1:0] r_mag;
    t_ctl r_ctl;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    // rotate both lanes
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_num <= cordic_step(i_num, STEP);
            r_den <= cordic_step(i_den, STEP);
            r_mag <= i_mag;
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;
    assign o_mag = r_mag;
    assign o_ctl = r_ctl;

endmodule

FILE: rtl/awd_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awd_div_cell
// One restoring division step, one quotient bit per cell.
// ----------------------------------------------------------------------------
module awd_div_cell #(
    parameter int QB       = 17,
    parameter int MAG_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic [awd_pkg::AW-1:0]    i_rem,
    input  logic [awd_pkg::AW-1:0]    i_den,
    input  logic [QB-1:0]             i_low,
    input  logic [QB-1:0]             i_quo,
    input  logic [MAG_BITS-1:0]       i_mag,
    input  awd_pkg::t_ctl             i_ctl,
    output logic [awd_pkg::AW-1:0]    o_rem,
    output logic [awd_pkg::AW-1:0]    o_den,
    output logic [QB-1:0]             o_low,
    output logic [QB-1:0]             o_quo,
    output logic [MAG_BITS-1:0]       o_mag,
    output awd_pkg::t_ctl             o_ctl
);
    import awd_pkg::*;

    logic [AW:0]   w_trial;
    logic [AW:0]   w_diff;
    logic          w_bit;
    logic [AW-1:0] r_rem;
    logic [AW-1:0] r_den;
    logic [QB-1:0] r_low;
    logic [QB-1:0] r_quo;
    logic [MAG_BITS-1:0] r_mag;
    t_ctl r_ctl;

    // bring down the next dividend bit and try to subtract
    assign w_trial = {i_rem, i_low[QB-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_bit   = (w_trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem <= w_bit ? w_diff[AW-1:0] : w_trial[AW-1:0];
            r_den <= i_den;
            r_low <= {i_low[QB-2:0], 1'b0};
            r_quo <= {i_quo[QB-2:0], w_bit};
            r_mag <= i_mag;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_low = r_low;
    assign o_quo = r_quo;
    assign o_mag = r_mag;
    assign o_ctl = r_ctl;

endmodule

FILE: rtl/awd_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awd_stage
// One waveshaping stage: gain product, cordic cell row, divider cell row and
// the result cell that clamps, inverts and fixes the sign of zero.
// ----------------------------------------------------------------------------
module awd_stage #(
    parameter int STG         = 0,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  logic [awd_pkg::GAIN_BITS-1:0]      i_pos_gain,
    input  logic [awd_pkg::GAIN_BITS-1:0]      i_neg_gain,
    input  logic                               i_invert,
    input  logic                               i_active,
    input  logic [SAMPLE_BITS-1:0]             i_mag,
    input  awd_pkg::t_ctl                      i_ctl,
    output logic [SAMPLE_BITS-1:0]             o_mag,
    output awd_pkg::t_ctl                      o_ctl
);
    import awd_pkg::*;

    localparam int F   = SAMPLE_BITS - 1;
    localparam int PW  = GAIN_BITS + SAMPLE_BITS;
    localparam int SH  = ANGLE_BITS - 8 - F;
    localparam int QB  = SAMPLE_BITS + 1;
    localparam int DVW = AW + F + 1;
    localparam bit EVEN = ((STG % 2) == 0);

    // ---- gain select and product cell
    logic [GAIN_BITS-1:0]   w_gain;
    logic [PW-1:0]          r_prod_n;
    logic [PW-1:0]          r_prod_d;
    logic [SAMPLE_BITS-1:0] r_p_mag;
    t_ctl                   r_p_ctl;
    t_ctl                   w_p_ctl;

    assign w_gain = i_ctl.neg ? i_neg_gain : i_pos_gain;

    always_comb begin
        w_p_ctl     = i_ctl;
        w_p_ctl.act = i_active;
        w_p_ctl.byp = !i_active || (w_gain == '0) || (i_mag == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
        end else if (i_adv) begin
            r_p_ctl <= w_p_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod_n <= PW'(w_gain) * PW'(i_mag);
            r_prod_d <= PW'(w_gain) << F;
            r_p_mag  <= i_mag;
        end
    end

    // ---- rescale products to units of 2^-30
    logic [CW-1:0] w_arg_n;
    logic [CW-1:0] w_arg_d;

    if (SH >= 0) begin : g_lsh
        assign w_arg_n = CW'(64'(r_prod_n) << SH);
        assign w_arg_d = CW'(64'(r_prod_d) << SH);
    end else begin : g_rsh
        localparam int RS = -SH;
        assign w_arg_n = CW'((64'(r_prod_n) + (64'd1 << (RS - 1))) >> RS);
        assign w_arg_d = CW'((64'(r_prod_d) + (64'd1 << (RS - 1))) >> RS);
    end

    // ---- cordic cell row
    t_rot                   w_num [0:CORDIC_STEPS];
    t_rot                   w_den [0:CORDIC_STEPS];
    logic [SAMPLE_BITS-1:0] w_cmag [0:CORDIC_STEPS];
    t_ctl                   w_cctl [0:CORDIC_STEPS];

    always_comb begin
        w_num[0].x = CW'(64'd1 << ANGLE_BITS);
        w_num[0].y = $signed(w_arg_n);
        w_num[0].z = '0;
        w_den[0].x = CW'(64'd1 << ANGLE_BITS);
        w_den[0].y = $signed(w_arg_d);
        w_den[0].z = '0;
    end
    assign w_cmag[0] = r_p_mag;
    assign w_cctl[0] = r_p_ctl;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        awd_cordic_cell #(
            .STEP     (k),
            .MAG_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (i_adv),
            .i_num   (w_num[k]),
            .i_den   (w_den[k]),
            .i_mag   (w_cmag[k]),
            .i_ctl   (w_cctl[k]),
            .o_num   (w_num[k+1]),
            .o_den   (w_den[k+1]),
            .o_mag   (w_cmag[k+1]),
            .o_ctl   (w_cctl[k+1])
        );
    end

    // ---- divider setup cell: clamp angles, form the rounded dividend
    logic [AW-1:0]  w_anum;
    logic [AW-1:0]  w_aden;
    logic [DVW-1:0] w_dvd;
    t_ctl           w_d_ctl;
    logic [AW-1:0]  r_rem0;
    logic [AW-1:0]  r_den0;
    logic [QB-1:0]  r_low0;
    logic [SAMPLE_BITS-1:0] r_d_mag;
    t_ctl           r_d_ctl;

    assign w_anum = w_num[CORDIC_STEPS].z[ZW-1] ? '0 : w_num[CORDIC_STEPS].z[AW-1:0];
    assign w_aden = w_den[CORDIC_STEPS].z[ZW-1] ? '0 : w_den[CORDIC_STEPS].z[AW-1:0];
    assign w_dvd  = (DVW'(w_anum) << F) + DVW'(w_aden >> 1);

    always_comb begin
        w_d_ctl     = w_cctl[CORDIC_STEPS];
        w_d_ctl.byp = w_cctl[CORDIC_STEPS].byp || (w_aden == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl <= '0;
        end else if (i_adv) begin
            r_d_ctl <= w_d_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem0  <= AW'(w_dvd >> QB);
            r_den0  <= w_aden;
            r_low0  <= w_dvd[QB-1:0];
            r_d_mag <= w_cmag[CORDIC_STEPS];
        end
    end

    // ---- divider cell row
    logic [AW-1:0]          w_rem  [0:QB];
    logic [AW-1:0]          w_dden [0:QB];
    logic [QB-1:0]          w_low  [0:QB];
    logic [QB-1:0]          w_quo  [0:QB];
    logic [SAMPLE_BITS-1:0] w_dmag [0:QB];
    t_ctl                   w_dctl [0:QB];

    assign w_rem[0]  = r_rem0;
    assign w_dden[0] = r_den0;
    assign w_low[0]  = r_low0;
    assign w_quo[0]  = '0;
    assign w_dmag[0] = r_d_mag;
    assign w_dctl[0] = r_d_ctl;

    for (genvar j = 0; j < QB; j++) begin : g_div
        awd_div_cell #(
            .QB       (QB),
            .MAG_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (i_adv),
            .i_rem   (w_rem[j]),
            .i_den   (w_dden[j]),
            .i_low   (w_low[j]),
            .i_quo   (w_quo[j]),
            .i_mag   (w_dmag[j]),
            .i_ctl   (w_dctl[j]),
            .o_rem   (w_rem[j+1]),
            .o_den   (w_dden[j+1]),
            .o_low   (w_low[j+1]),
            .o_quo   (w_quo[j+1]),
            .o_mag   (w_dmag[j+1]),
            .o_ctl   (w_dctl[j+1])
        );
    end

    // ---- result cell: clamp to one, invert on even stages, zero is positive
    logic [QB-1:0]          w_q;
    logic [SAMPLE_BITS-1:0] n_mag;
    t_ctl                   n_ctl;
    t_ctl                   w_fctl;
    logic [SAMPLE_BITS-1:0] r_mag;
    t_ctl                   r_ctl;

    assign w_q    = w_quo[QB];
    assign w_fctl = w_dctl[QB];

    always_comb begin
        n_ctl = w_fctl;
        if (w_fctl.byp) begin
            n_mag = w_dmag[QB];
        end else if (w_q > (QB'(1) << F)) begin
            n_mag = SAMPLE_BITS'(1) << F;
        end else begin
            n_mag = w_q[SAMPLE_BITS-1:0];
        end
        if (w_fctl.act) begin
            if (i_invert && EVEN) begin
                n_ctl.neg = !w_fctl.neg;
            end
            if (n_mag == '0) begin
                n_ctl.neg = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mag <= n_mag;
        end
    end

    assign o_mag = r_mag;
    assign o_ctl = r_ctl;

endmodule

FILE: rtl/arctan_waveshaper_distortion_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arctan_waveshaper_distortion_core
// Cascade of asymmetric arctangent soft-clip stages on signed Q1.F samples.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the skid register is empty; each stage
// is a row of 30 cordic cells and SAMPLE_BITS + 1 divider cells that all
// advance together
// a skid register behind the output takes one more word while the output stalls
// reset: synchronous, active low; clears valid flags and loads gains of 1.0,
// no inversion and one stage
module arctan_waveshaper_distortion_core #(
    parameter int MAX_STAGES  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_sample_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [1:0]                           i_cfg_index,
    input  logic [awd_pkg::CFG_BITS-1:0]         i_cfg_data
);
    import awd_pkg::*;

    localparam int F = SAMPLE_BITS - 1;

    // ---- configuration registers
    logic [GAIN_BITS-1:0]  r_pos_gain;
    logic [GAIN_BITS-1:0]  r_neg_gain;
    logic                  r_invert;
    logic [COUNT_BITS-1:0] r_stage_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_gain    <= GAIN_BITS'(256);
            r_neg_gain    <= GAIN_BITS'(256);
            r_invert      <= 1'b0;
            r_stage_count <= COUNT_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_POS_GAIN:    r_pos_gain    <= i_cfg_data[GAIN_BITS-1:0];
                CFG_NEG_GAIN:    r_neg_gain    <= i_cfg_data[GAIN_BITS-1:0];
                CFG_INVERT:      r_invert      <= i_cfg_data[0];
                CFG_STAGE_COUNT: r_stage_count <= i_cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---- flow control: the whole chain moves while the skid register is empty
    logic w_adv;
    logic r_skid_valid;
    logic [SAMPLE_BITS-1:0] r_skid_data;
    logic r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_data;

    assign w_adv      = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    // ---- input cell: sign and magnitude
    logic [SAMPLE_BITS-1:0] r_in_mag;
    t_ctl                   r_in_ctl;
    t_ctl                   n_in_ctl;

    always_comb begin
        n_in_ctl       = '0;
        n_in_ctl.valid = i_in_valid;
        n_in_ctl.neg   = i_sample_in[F];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else if (w_adv) begin
            r_in_ctl <= n_in_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_mag <= i_sample_in[F] ? SAMPLE_BITS'(-i_sample_in) : i_sample_in;
        end
    end

    // ---- stage chain
    logic [SAMPLE_BITS-1:0] w_mag [0:MAX_STAGES];
    t_ctl                   w_ctl [0:MAX_STAGES];

    assign w_mag[0] = r_in_mag;
    assign w_ctl[0] = r_in_ctl;

    for (genvar s = 0; s < MAX_STAGES; s++) begin : g_stage
        logic w_active;
        assign w_active = (5'(s) < {1'b0, r_stage_count});

        awd_stage #(
            .STG         (s),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_pos_gain (r_pos_gain),
            .i_neg_gain (r_neg_gain),
            .i_invert   (r_invert),
            .i_active   (w_active),
            .i_mag      (w_mag[s]),
            .i_ctl      (w_ctl[s]),
            .o_mag      (w_mag[s+1]),
            .o_ctl      (w_ctl[s+1])
        );
    end

    // ---- back to two's complement with saturation of plus one
    logic [SAMPLE_BITS-1:0] w_res;
    logic                   w_res_valid;

    assign w_res_valid = w_ctl[MAX_STAGES].valid;

    always_comb begin
        if (w_ctl[MAX_STAGES].neg) begin
            w_res = SAMPLE_BITS'(-w_mag[MAX_STAGES]);
        end else if (w_mag[MAX_STAGES][F]) begin
            w_res = {1'b0, {F{1'b1}}};
        end else begin
            w_res = w_mag[MAX_STAGES];
        end
    end

    // ---- output register and skid register
    logic w_take;
    assign w_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || w_take) begin
            r_out_valid <= w_res_valid;
        end else if (w_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (!r_out_valid || w_take) begin
            r_out_data <= w_res;
        end else begin
            r_skid_data <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;

endmodule

FILE: rtl/awd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awd_checker
// Port-level checks of the waveshaper flow control, bound to the top level.
// ----------------------------------------------------------------------------
module awd_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic signed [SAMPLE_BITS-1:0] o_sample_out
);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_out))
        else $error("stalled output word changed");

    // input stall only follows a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // skid word drains as soon as the output moves
    a_stall_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && !i_out_stall |=> !o_in_stall)
        else $error("input stall held after output was taken");

    // skid word implies a waiting output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

endmodule

bind arctan_waveshaper_distortion_core awd_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_awd_checker (.*);
